[design/inverse_julia_iteration_point_unit_macros.svh]
// Assertion macros for the inverse Julia iteration point unit.
// Used by the controller and datapath; they need clk_i and rst_ni in scope.
`ifndef INVERSE_JULIA_ITERATION_POINT_UNIT_MACROS_SVH
`define INVERSE_JULIA_ITERATION_POINT_UNIT_MACROS_SVH
`ifndef SYNTH
`define IJ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ij assertion failed");
`define IJ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ij assertion failed");
`else
`define IJ_ASSERT(lbl, prop)
`define IJ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/ijip_pkg.sv]
// Shared constants, types and helpers of the inverse Julia iteration point unit.
// No dependencies.
`timescale 1ns / 1ps
package ijip_pkg;
  localparam int FRAC_BITS = 16;
  localparam int PT_W      = 20;             // point and constant width
  localparam int DIFF_W    = PT_W + 1;       // z - c
  localparam int PROD_W    = 2 * DIFF_W;     // multiplier result
  localparam int THR_W     = 14;
  localparam int SCALE_W   = 19;
  localparam int M_W       = 21;             // magnitude root width
  localparam int SUM_W     = M_W + 2;        // m +/- dx
  localparam int RAD_RAW   = (SUM_W + FRAC_BITS - 1 > 42) ? SUM_W + FRAC_BITS - 1 : 42;
  localparam int RAD_W     = RAD_RAW + (RAD_RAW % 2);
  localparam int HALF      = RAD_W / 2;      // root width and step count
  localparam int REM_W     = HALF + 2;
  localparam int CNT_W     = $clog2(HALF + 1);

  localparam logic [1:0] REG_C_RE  = 2'd0;
  localparam logic [1:0] REG_C_IM  = 2'd1;
  localparam logic [1:0] REG_THR   = 2'd2;
  localparam logic [1:0] REG_SCALE = 2'd3;

  localparam logic [1:0] MUL_DX = 2'd0;
  localparam logic [1:0] MUL_DY = 2'd1;
  localparam logic [1:0] MUL_X  = 2'd2;
  localparam logic [1:0] MUL_Y  = 2'd3;

  localparam logic [1:0] RAD_ACC   = 2'd0;
  localparam logic [1:0] RAD_PLUS  = 2'd1;
  localparam logic [1:0] RAD_MINUS = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_load;
    logic       acc_add;
    logic       sqrt_load;
    logic [1:0] rad_sel;
    logic       sqrt_step;
    logic       store_m;
    logic       store_re;
    logic       store_im;
    logic       upd_cur;
    logic       px_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } sts_t;

  localparam logic signed [PROD_W-1:0] PT_MAX = PROD_W'(524287);
  localparam logic signed [PROD_W-1:0] PT_MIN = -PROD_W'(524288);

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [PROD_W-1:0] v);
    logic signed [PT_W-1:0] r;
    if (v > PT_MAX) r = PT_MAX[PT_W-1:0];
    else if (v < PT_MIN) r = PT_MIN[PT_W-1:0];
    else r = v[PT_W-1:0];
    return r;
  endfunction
endpackage

[design/inverse_julia_iteration_point_unit.sv]
// Inverse Julia iteration point unit: one new Julia set point per input draw. Each accepted
// draw is processed by three passes of one shared digit-by-digit square root unit (one
// root bit per cycle, 21 steps plus load and store per pass: magnitude, real part, imaginary
// part) and four passes through one registered 21x21 multiplier. The next draw can be taken
// in the cycle after the result is loaded into the output register, even while that result
// still waits on out_stall_i, so a new draw is accepted only once the previous one is done.
// Configuration (c_re, c_im, threshold, scale at indexes 0..3) is to be written by the user
// through cfg_we_i/cfg_index_i/cfg_data_i only while idle; the block does not enforce it;
// reset loads c = -0.75 + 0.23i, threshold 8700 and scale 3.5, and clears the point z.
// Depends on ijip_pkg, ijip_ctrl and ijip_datapath.
`timescale 1ns / 1ps
module inverse_julia_iteration_point_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [ijip_pkg::PT_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ijip_pkg::THR_W-1:0]         rand_draw_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ijip_pkg::PT_W-1:0]   point_x_o,
  output logic signed [ijip_pkg::PT_W-1:0]   point_y_o
);
  import ijip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing and both handshakes
  ijip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic, point state and the output register
  ijip_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rand_draw_i (rand_draw_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o)
  );
endmodule

[design/ijip_datapath.sv]
// Datapath: config registers, shared multiplier, digit-by-digit square root, point state.
// Depends on ijip_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "inverse_julia_iteration_point_unit_macros.svh"
module ijip_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [ijip_pkg::PT_W-1:0]      cfg_data_i,
  input  logic [ijip_pkg::THR_W-1:0]     rand_draw_i,
  input  ijip_pkg::cmd_t                 cmd_i,
  output ijip_pkg::sts_t                 sts_o,
  output logic signed [ijip_pkg::PT_W-1:0] point_x_o,
  output logic signed [ijip_pkg::PT_W-1:0] point_y_o
);
  import ijip_pkg::*;

  logic signed [PT_W-1:0]   c_re_q, c_im_q, cur_re_q, cur_im_q;
  logic [THR_W-1:0]         thr_q, draw_q;
  logic [SCALE_W-1:0]       scale_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic [RAD_W-1:0]         acc_q, rad_q, rad_d;
  logic [REM_W-1:0]         rem_q, rem_sh, trial;
  logic [HALF-1:0]          root_q, re_q, im_q;
  logic [M_W-1:0]           m_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [SUM_W-1:0]  plus, minus;
  logic                     neg_root, neg_im;
  logic signed [PROD_W-1:0] re_v, im_v;
  logic signed [PT_W-1:0]   px_tmp_q, point_x_q, point_y_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_re_q  <= -PT_W'(49152);
      c_im_q  <= PT_W'(15073);
      thr_q   <= THR_W'(8700);
      scale_q <= SCALE_W'(229376);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_C_RE:  c_re_q  <= cfg_data_i;
        REG_C_IM:  c_im_q  <= cfg_data_i;
        REG_THR:   thr_q   <= cfg_data_i[THR_W-1:0];
        REG_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_DX: begin mul_a = dx_q; mul_b = dx_q; end
      MUL_DY: begin mul_a = dy_q; mul_b = dy_q; end
      MUL_X:  begin mul_a = DIFF_W'(cur_re_q); mul_b = $signed({2'b00, scale_q}); end
      default: begin mul_a = DIFF_W'(cur_im_q); mul_b = $signed({2'b00, scale_q}); end
    endcase
  end

  assign plus  = SUM_W'($signed({1'b0, m_q})) + SUM_W'(dx_q);
  assign minus = SUM_W'($signed({1'b0, m_q})) - SUM_W'(dx_q);

  always_comb begin
    case (cmd_i.rad_sel)
      RAD_ACC:  rad_d = acc_q;
      RAD_PLUS: rad_d = RAD_W'($unsigned(plus)) << (FRAC_BITS - 1);
      default:  rad_d = RAD_W'($unsigned(minus)) << (FRAC_BITS - 1);
    endcase
  end

  // one root digit per step
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  assign neg_root = !(draw_q > thr_q);
  assign neg_im   = dy_q[DIFF_W-1] ^ neg_root;
  assign re_v = neg_root ? -PROD_W'($signed({1'b0, re_q})) : PROD_W'($signed({1'b0, re_q}));
  assign im_v = neg_im ? -PROD_W'($signed({1'b0, im_q})) : PROD_W'($signed({1'b0, im_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_re_q <= '0;
      cur_im_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.upd_cur) begin
        cur_re_q <= sat_pt(re_v);
        cur_im_q <= sat_pt(im_v);
      end
      if (cmd_i.sqrt_load) cnt_q <= CNT_W'(HALF);
      else if (cmd_i.sqrt_step) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      draw_q <= rand_draw_i;
      dx_q   <= DIFF_W'(cur_re_q) - DIFF_W'(c_re_q);
      dy_q   <= DIFF_W'(cur_im_q) - DIFF_W'(c_im_q);
    end
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.acc_load) acc_q <= RAD_W'($unsigned(prod_q));
    else if (cmd_i.acc_add) acc_q <= acc_q + RAD_W'($unsigned(prod_q));
    if (cmd_i.sqrt_load) begin
      rad_q  <= rad_d;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[HALF-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[HALF-2:0], 1'b0};
      end
    end
    if (cmd_i.store_m)  m_q  <= root_q[M_W-1:0];
    if (cmd_i.store_re) re_q <= root_q;
    if (cmd_i.store_im) im_q <= root_q;
    if (cmd_i.px_load)  px_tmp_q <= sat_pt(prod_q >>> FRAC_BITS);
    if (cmd_i.out_load) begin
      point_x_q <= px_tmp_q;
      point_y_q <= sat_pt(prod_q >>> FRAC_BITS);
    end
  end

  assign sts_o.sqrt_done = (cnt_q == '0);
  assign point_x_o = point_x_q;
  assign point_y_o = point_y_q;

  `IJ_ASSERT(a_cnt_range, cnt_q <= CNT_W'(HALF))
  `IJ_ASSERT_NEXT(a_load_cnt, cmd_i.sqrt_load, cnt_q == CNT_W'(HALF))
  `IJ_ASSERT(a_store_done, (cmd_i.store_m || cmd_i.store_re || cmd_i.store_im) |-> sts_o.sqrt_done)
endmodule

[design/ijip_ctrl.sv]
// Controller state machine: sequences the datapath and owns both handshakes.
// Depends on ijip_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "inverse_julia_iteration_point_unit_macros.svh"
module ijip_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ijip_pkg::sts_t sts_i,
  output ijip_pkg::cmd_t cmd_o
);
  import ijip_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQX    = 4'd1;
  localparam logic [3:0] S_SQY    = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_LD_M   = 4'd4;
  localparam logic [3:0] S_RUN_M  = 4'd5;
  localparam logic [3:0] S_LD_RE  = 4'd6;
  localparam logic [3:0] S_RUN_RE = 4'd7;
  localparam logic [3:0] S_LD_IM  = 4'd8;
  localparam logic [3:0] S_RUN_IM = 4'd9;
  localparam logic [3:0] S_UPD    = 4'd10;
  localparam logic [3:0] S_MULX   = 4'd11;
  localparam logic [3:0] S_MULY   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d, out_free, accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: if (accept) begin cmd_o.capture = 1'b1; state_d = S_SQX; end
      S_SQX: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_DX; state_d = S_SQY;
      end
      S_SQY: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_DY; cmd_o.acc_load = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin cmd_o.acc_add = 1'b1; state_d = S_LD_M; end
      S_LD_M: begin
        cmd_o.sqrt_load = 1'b1; cmd_o.rad_sel = RAD_ACC; state_d = S_RUN_M;
      end
      S_RUN_M: begin
        if (sts_i.sqrt_done) begin cmd_o.store_m = 1'b1; state_d = S_LD_RE; end
        else cmd_o.sqrt_step = 1'b1;
      end
      S_LD_RE: begin
        cmd_o.sqrt_load = 1'b1; cmd_o.rad_sel = RAD_PLUS; state_d = S_RUN_RE;
      end
      S_RUN_RE: begin
        if (sts_i.sqrt_done) begin cmd_o.store_re = 1'b1; state_d = S_LD_IM; end
        else cmd_o.sqrt_step = 1'b1;
      end
      S_LD_IM: begin
        cmd_o.sqrt_load = 1'b1; cmd_o.rad_sel = RAD_MINUS; state_d = S_RUN_IM;
      end
      S_RUN_IM: begin
        if (sts_i.sqrt_done) begin cmd_o.store_im = 1'b1; state_d = S_UPD; end
        else cmd_o.sqrt_step = 1'b1;
      end
      S_UPD: begin cmd_o.upd_cur = 1'b1; state_d = S_MULX; end
      S_MULX: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_X; state_d = S_MULY;
      end
      S_MULY: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_Y; cmd_o.px_load = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1; out_valid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `IJ_ASSERT_NEXT(a_accept_starts, accept, state_q == S_SQX)
  `IJ_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `IJ_ASSERT_NEXT(a_m_then_re, state_q == S_RUN_M && sts_i.sqrt_done, state_q == S_LD_RE)
endmodule
